// ----- rtl/assert_macros.svh -----
// Assertion macros for the LED pattern controller checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock edge outside reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Implication with the consequent checked in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/mlpc_pkg.sv -----
// Shared constants, types and the load_time function of the LED pattern controller
package mlpc_pkg;

	localparam int NUM_LEDS   = 4;
	localparam int TIME_WIDTH = 16;
	localparam int REG_WIDTH  = 16;
	localparam int OUT_LEDS   = 4;

	localparam logic [31:0] TIME_MAX = 32'((64'd1 << TIME_WIDTH) - 64'd1);

	localparam logic [REG_WIDTH-1:0] HB_ON_RESET  = 16'd100;
	localparam logic [REG_WIDTH-1:0] HB_OFF_RESET = 16'd2900;
	localparam logic [REG_WIDTH-1:0] GAP_RESET    = 16'd150;

	localparam logic [2:0] FUNC_TICK      = 3'd0;
	localparam logic [2:0] FUNC_STEADY    = 3'd1;
	localparam logic [2:0] FUNC_BLINK     = 3'd2;
	localparam logic [2:0] FUNC_HEARTBEAT = 3'd3;
	localparam logic [2:0] FUNC_LATCH     = 3'd4;

	localparam logic [1:0] CFG_HB_ON  = 2'd0;
	localparam logic [1:0] CFG_HB_OFF = 2'd1;
	localparam logic [1:0] CFG_GAP    = 2'd2;

	typedef struct packed {
		logic                 tick;
		logic                 hit;
		logic [2:0]           func;
		logic                 level;
		logic [REG_WIDTH-1:0] period;
	} led_cmd_t;

	typedef struct packed {
		logic [REG_WIDTH-1:0] hb_on;
		logic [REG_WIDTH-1:0] hb_off;
		logic [REG_WIDTH-1:0] gap;
	} led_cfg_t;

	function automatic logic [TIME_WIDTH-1:0] load_time(input logic [REG_WIDTH-1:0] t);
		logic [31:0] v;
		v = 32'(t);
		if (v == 32'd0)
			v = 32'd1;
		if (v > TIME_MAX)
			v = TIME_MAX;
		return v[TIME_WIDTH-1:0];
	endfunction

endpackage

// ----- rtl/mlpc_led.sv -----
// State and countdown of one LED
module mlpc_led (
	input  logic              clk,
	input  logic              arst_n,
	input  mlpc_pkg::led_cmd_t cmd,
	input  mlpc_pkg::led_cfg_t cfg,
	output logic              level_d
);
	import mlpc_pkg::*;

	typedef enum logic [1:0] {
		MODE_STEADY    = 2'd0,
		MODE_BLINK     = 2'd1,
		MODE_LATCH     = 2'd2,
		MODE_HEARTBEAT = 2'd3
	} mode_t;

	mode_t                 mode_q, mode_d;
	logic                  level_q;
	logic [REG_WIDTH-1:0]  half_q, half_d;
	logic [TIME_WIDTH-1:0] rem_q, rem_d;
	logic [REG_WIDTH-1:0]  period_fix;

	assign period_fix = (cmd.period == '0) ? REG_WIDTH'(1) : cmd.period;

	always_comb begin
		mode_d  = mode_q;
		level_d = level_q;
		half_d  = half_q;
		rem_d   = rem_q;
		if (cmd.hit) begin
			case (cmd.func)
				FUNC_STEADY: begin
					mode_d  = MODE_STEADY;
					level_d = cmd.level;
					rem_d   = '0;
				end
				FUNC_BLINK: begin
					mode_d  = MODE_BLINK;
					half_d  = period_fix;
					level_d = 1'b1;
					rem_d   = load_time(period_fix);
				end
				FUNC_HEARTBEAT: begin
					mode_d  = MODE_HEARTBEAT;
					level_d = 1'b1;
					rem_d   = load_time(cfg.hb_on);
				end
				FUNC_LATCH: begin
					mode_d  = MODE_LATCH;
					level_d = 1'b0;
					rem_d   = load_time(cfg.gap);
				end
				default: begin
				end
			endcase
		end else if (cmd.tick && rem_q != '0) begin
			rem_d = rem_q - 1'b1;
			if (rem_d == '0) begin
				if (mode_q == MODE_LATCH) begin
					mode_d  = MODE_STEADY;
					level_d = 1'b1;
				end else begin
					level_d = ~level_q;
					if (mode_q == MODE_HEARTBEAT)
						rem_d = load_time(level_d ? cfg.hb_on : cfg.hb_off);
					else if (mode_q == MODE_BLINK)
						rem_d = load_time(half_q);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_STEADY;
			level_q <= 1'b0;
			half_q  <= '0;
			rem_q   <= '0;
		end else if (cmd.hit || cmd.tick) begin
			mode_q  <= mode_d;
			level_q <= level_d;
			half_q  <= half_d;
			rem_q   <= rem_d;
		end
	end

endmodule

// ----- rtl/multi_led_pattern_controller.sv -----
// Top level of the LED pattern controller: input stage, LED bank, result register
//
//  channel | direction | handshake            | payload
//  in      | input     | in_valid / in_stall   | func, led_select, level, blink_period
//  out     | output    | out_valid / out_stall | led_levels
//  cfg     | input     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// One word per cycle unless stalled; the input register holds a word until it advances.
// The LED bank updates from the input register in one pass into the result register.
// Reset restores the register defaults and puts every LED steady and dark.
// A held result stalls the input stage once it is full; cfg_ready stays high.
module multi_led_pattern_controller (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [2:0]                     func,
	input  logic [1:0]                     led_select,
	input  logic                           level,
	input  logic [mlpc_pkg::REG_WIDTH-1:0] blink_period,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [mlpc_pkg::OUT_LEDS-1:0]  led_levels,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [1:0]                     cfg_index,
	input  logic [mlpc_pkg::REG_WIDTH-1:0] cfg_data
);
	import mlpc_pkg::*;

	logic                 valid_s1;
	logic [2:0]           func_s1;
	logic [1:0]           sel_s1;
	logic                 level_s1;
	logic [REG_WIDTH-1:0] period_s1;
	logic                 advance;
	logic                 out_valid_q;
	logic [OUT_LEDS-1:0]  levels_q;
	logic [NUM_LEDS-1:0]  level_next;
	logic [OUT_LEDS-1:0]  levels_d;
	logic                 is_cmd;
	led_cfg_t             cfg_q;

	assign advance   = !(out_valid_q && out_stall);
	assign in_stall  = valid_s1 && !advance;
	assign out_valid = out_valid_q;
	assign led_levels = levels_q;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.hb_on  <= HB_ON_RESET;
			cfg_q.hb_off <= HB_OFF_RESET;
			cfg_q.gap    <= GAP_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_HB_ON:  cfg_q.hb_on  <= cfg_data;
				CFG_HB_OFF: cfg_q.hb_off <= cfg_data;
				CFG_GAP:    cfg_q.gap    <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance || !valid_s1) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			func_s1   <= func;
			sel_s1    <= led_select;
			level_s1  <= level;
			period_s1 <= blink_period;
		end
	end

	assign is_cmd = (func_s1 == FUNC_STEADY) || (func_s1 == FUNC_BLINK) ||
		(func_s1 == FUNC_HEARTBEAT) || (func_s1 == FUNC_LATCH);

	for (genvar i = 0; i < NUM_LEDS; i++) begin : g_led
		led_cmd_t cmd;
		assign cmd.tick   = valid_s1 && advance && (func_s1 == FUNC_TICK);
		assign cmd.hit    = valid_s1 && advance && is_cmd && (32'(sel_s1) == i);
		assign cmd.func   = func_s1;
		assign cmd.level  = level_s1;
		assign cmd.period = period_s1;
		mlpc_led u_led (
			.clk     (clk),
			.arst_n  (arst_n),
			.cmd     (cmd),
			.cfg     (cfg_q),
			.level_d (level_next[i])
		);
	end

	for (genvar j = 0; j < OUT_LEDS; j++) begin : g_out
		if (j < NUM_LEDS) begin : g_on
			assign levels_d[j] = level_next[j];
		end else begin : g_off
			assign levels_d[j] = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1)
			levels_q <= levels_d;
	end

endmodule

// ----- rtl/mlpc_checker.sv -----
// Port checks of the LED pattern controller and their binding
`include "assert_macros.svh"

module mlpc_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           in_valid,
	input logic                           in_stall,
	input logic                           out_valid,
	input logic                           out_stall,
	input logic [mlpc_pkg::OUT_LEDS-1:0]  led_levels,
	input logic                           cfg_valid,
	input logic                           cfg_ready
);
	import mlpc_pkg::*;

	`ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid, "result dropped while stalled")
	`ASSERT_NEXT(a_out_stable, clk, arst_n, out_valid && out_stall, $stable(led_levels), "result changed while stalled")
	`ASSERT_IMPL(a_stall_cause, clk, arst_n, in_stall, out_valid && out_stall, "input stalled without a held result")
	`ASSERT_IMPL(a_cfg_ready, clk, arst_n, cfg_valid, cfg_ready, "configuration write refused")
	`ASSERT_IMPL(a_latency, clk, arst_n, in_valid && !in_stall && !out_valid, ##2 out_valid, "result missing two cycles after an idle accept")

endmodule

bind multi_led_pattern_controller mlpc_checker u_mlpc_checker (.*);

// ----- bench/tb_multi_led_pattern_controller.sv -----
// Self-checking bench for the LED pattern controller: directed table, random words, timing setups
`timescale 1ns / 100ps

module tb_multi_led_pattern_controller;
	import mlpc_pkg::*;

	localparam logic [2:0] FUNC_SPARE_A = 3'd5;
	localparam logic [2:0] FUNC_SPARE_B = 3'd6;
	localparam logic [2:0] FUNC_SPARE_C = 3'd7;
	localparam logic [1:0] CFG_SPARE    = 2'd3;
	localparam int unsigned HOLD_CYCLES = 150;
	localparam int unsigned IDLE_LIMIT  = 2000;

	typedef enum logic [1:0] {BANK_STEADY, BANK_FLASH, BANK_HOLDOFF, BANK_PULSE} bank_mode_t;

	typedef struct {
		logic [2:0]  fn;
		logic [1:0]  sel;
		logic        lvl;
		logic [15:0] per;
		bit          known;
		logic [3:0]  want;
	} cmd_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [2:0]  func = FUNC_TICK;
	logic [1:0]  led_select = 2'd0;
	logic        level = 1'b0;
	logic [15:0] blink_period = 16'd0;
	logic        out_valid;
	logic        out_stall = 1'b1;
	logic [3:0]  led_levels;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = CFG_HB_ON;
	logic [15:0] cfg_data = 16'd0;

	bank_mode_t  mode_q[NUM_LEDS];
	logic        lit_q[NUM_LEDS];
	logic [15:0] half_period_q[NUM_LEDS];
	logic [15:0] countdown_q[NUM_LEDS];
	logic [15:0] hb_on_q, hb_off_q, gap_q;

	logic [3:0]  expected_levels[$];
	logic [3:0]  oldest_levels;
	int unsigned mismatches = 0;
	bit          tx_quiet = 1'b0;
	bit          rx_quiet = 1'b0;
	bit          hold_req = 1'b0;

	multi_led_pattern_controller dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.func(func),
		.led_select(led_select),
		.level(level),
		.blink_period(blink_period),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.led_levels(led_levels),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #1 clk = ~clk;

	function automatic logic [15:0] at_least_one(input logic [15:0] t);
		return (t == 16'd0) ? 16'd1 : t;
	endfunction

	function automatic void clear_bank();
		hb_on_q  = HB_ON_RESET;
		hb_off_q = HB_OFF_RESET;
		gap_q    = GAP_RESET;
		for (int i = 0; i < NUM_LEDS; i++) begin
			mode_q[i]        = BANK_STEADY;
			lit_q[i]         = 1'b0;
			half_period_q[i] = 16'd0;
			countdown_q[i]   = 16'd0;
		end
	endfunction

	function automatic logic [3:0] advance_bank(input logic [2:0] f, input logic [1:0] s,
		input logic l, input logic [15:0] p);
		logic [3:0] lv;
		if (f == FUNC_TICK) begin
			for (int i = 0; i < NUM_LEDS; i++) begin
				if (countdown_q[i] != 16'd0) begin
					countdown_q[i] = countdown_q[i] - 16'd1;
					if (countdown_q[i] == 16'd0) begin
						if (mode_q[i] == BANK_HOLDOFF) begin
							mode_q[i] = BANK_STEADY;
							lit_q[i]  = 1'b1;
						end else begin
							lit_q[i] = ~lit_q[i];
							if (mode_q[i] == BANK_PULSE)
								countdown_q[i] = at_least_one(lit_q[i] ? hb_on_q : hb_off_q);
							else if (mode_q[i] == BANK_FLASH)
								countdown_q[i] = at_least_one(half_period_q[i]);
						end
					end
				end
			end
		end else begin
			case (f)
				FUNC_STEADY: begin
					mode_q[s]      = BANK_STEADY;
					lit_q[s]       = l;
					countdown_q[s] = 16'd0;
				end
				FUNC_BLINK: begin
					mode_q[s]        = BANK_FLASH;
					half_period_q[s] = at_least_one(p);
					lit_q[s]         = 1'b1;
					countdown_q[s]   = at_least_one(p);
				end
				FUNC_HEARTBEAT: begin
					mode_q[s]      = BANK_PULSE;
					lit_q[s]       = 1'b1;
					countdown_q[s] = at_least_one(hb_on_q);
				end
				FUNC_LATCH: begin
					mode_q[s]      = BANK_HOLDOFF;
					lit_q[s]       = 1'b0;
					countdown_q[s] = at_least_one(gap_q);
				end
				default: ;
			endcase
		end
		for (int i = 0; i < 4; i++)
			lv[i] = lit_q[i];
		return lv;
	endfunction

	task automatic offer_word(input logic [2:0] f, input logic [1:0] s, input logic l,
		input logic [15:0] p, input bit known, input logic [3:0] want);
		int unsigned gap;
		logic [3:0] predicted;
		gap = tx_quiet ? 0 : $urandom_range(0, 16);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid     <= 1'b1;
		func         <= f;
		led_select   <= s;
		level        <= l;
		blink_period <= p;
		@(posedge clk);
		while (in_stall !== 1'b0) @(posedge clk);
		predicted = advance_bank(f, s, l, p);
		expected_levels.push_back(known ? want : predicted);
	endtask

	task automatic random_words(input int unsigned n);
		int unsigned pick;
		logic [2:0] f;
		logic [15:0] p;
		repeat (n) begin
			pick = $urandom_range(0, 99);
			if (pick < 45)
				f = FUNC_TICK;
			else if (pick < 55)
				f = FUNC_STEADY;
			else if (pick < 68)
				f = FUNC_BLINK;
			else if (pick < 78)
				f = FUNC_HEARTBEAT;
			else if (pick < 90)
				f = FUNC_LATCH;
			else
				f = 3'($urandom_range(FUNC_SPARE_A, FUNC_SPARE_C));
			p = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(0, 65535))
				: 16'($urandom_range(0, 5));
			offer_word(f, 2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)), p, 1'b0, 4'd0);
		end
	endtask

	task automatic settle_bank();
		in_valid <= 1'b0;
		while (expected_levels.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic program_timing(input logic [15:0] on_ms, input logic [15:0] off_ms,
		input logic [15:0] gap_ms);
		logic [1:0]  idx[4];
		logic [15:0] val[4];
		idx = '{CFG_HB_ON, CFG_HB_OFF, CFG_GAP, CFG_SPARE};
		val = '{on_ms, off_ms, gap_ms, 16'($urandom_range(0, 65535))};
		for (int i = 0; i < 4; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= idx[i];
			cfg_data  <= val[i];
			@(posedge clk);
			while (cfg_ready !== 1'b1) @(posedge clk);
			case (idx[i])
				CFG_HB_ON:  hb_on_q  = val[i];
				CFG_HB_OFF: hb_off_q = val[i];
				CFG_GAP:    gap_q    = val[i];
				default: ;
			endcase
		end
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
			if (expected_levels.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected word: led_levels=%b", led_levels);
			end else begin
				oldest_levels = expected_levels.pop_front();
				if (led_levels !== oldest_levels) begin
					mismatches++;
					if (mismatches <= 10)
						$display("led_levels differ: expected %b, got %b",
							oldest_levels, led_levels);
				end
			end
		end
	end

	initial begin : receiver
		int unsigned n;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_req) begin
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end
			n = rx_quiet ? 0 : $urandom_range(0, 16);
			if (n != 0) begin
				out_stall <= 1'b1;
				repeat (n) @(posedge clk);
			end
			out_stall <= 1'b0;
			@(posedge clk);
			while (out_valid !== 1'b1) @(posedge clk);
		end
	end

	initial begin : watchdog
		int unsigned idle_run;
		idle_run = 0;
		while (idle_run < IDLE_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall)
				|| (cfg_valid && cfg_ready === 1'b1))
				idle_run = 0;
			else
				idle_run++;
		end
		$display("multi_led_pattern_controller: mismatch");
		$finish;
	end

	initial begin : stimulus
		cmd_row_t rows[21];
		logic [15:0] setups[6][3];
		rows = '{
			'{FUNC_TICK,      2'd0, 1'b0, 16'h0000, 1'b1, 4'b0000},
			'{FUNC_STEADY,    2'd0, 1'b1, 16'hFFFF, 1'b1, 4'b0001},
			'{FUNC_STEADY,    2'd3, 1'b1, 16'h0000, 1'b1, 4'b1001},
			'{FUNC_STEADY,    2'd3, 1'b0, 16'h0000, 1'b1, 4'b0001},
			'{FUNC_BLINK,     2'd1, 1'b0, 16'h0000, 1'b1, 4'b0011},
			'{FUNC_TICK,      2'd2, 1'b1, 16'h0000, 1'b1, 4'b0001},
			'{FUNC_TICK,      2'd1, 1'b0, 16'hFFFF, 1'b1, 4'b0011},
			'{FUNC_BLINK,     2'd2, 1'b1, 16'hFFFF, 1'b1, 4'b0111},
			'{FUNC_HEARTBEAT, 2'd3, 1'b0, 16'h0000, 1'b1, 4'b1111},
			'{FUNC_LATCH,     2'd0, 1'b1, 16'h0000, 1'b1, 4'b1110},
			'{FUNC_SPARE_A,   2'd0, 1'b1, 16'hFFFF, 1'b0, 4'b0000},
			'{FUNC_SPARE_B,   2'd1, 1'b0, 16'h0001, 1'b0, 4'b0000},
			'{FUNC_SPARE_C,   2'd3, 1'b1, 16'h8000, 1'b0, 4'b0000},
			'{FUNC_TICK,      2'd0, 1'b0, 16'h0000, 1'b0, 4'b0000},
			'{FUNC_BLINK,     2'd1, 1'b1, 16'h0002, 1'b0, 4'b0000},
			'{FUNC_TICK,      2'd0, 1'b0, 16'h0000, 1'b0, 4'b0000},
			'{FUNC_TICK,      2'd0, 1'b0, 16'h0000, 1'b0, 4'b0000},
			'{FUNC_TICK,      2'd0, 1'b0, 16'h0000, 1'b0, 4'b0000},
			'{FUNC_STEADY,    2'd2, 1'b1, 16'h5555, 1'b0, 4'b0000},
			'{FUNC_LATCH,     2'd3, 1'b0, 16'hAAAA, 1'b0, 4'b0000},
			'{FUNC_TICK,      2'd0, 1'b0, 16'h0000, 1'b0, 4'b0000}
		};
		setups = '{
			'{16'd1, 16'd1, 16'd1},
			'{16'd0, 16'd0, 16'd0},
			'{16'hFFFF, 16'hFFFF, 16'hFFFF},
			'{16'd3, 16'd7, 16'd2},
			'{16'($urandom_range(1, 12)), 16'($urandom_range(1, 12)),
				16'($urandom_range(1, 12))},
			'{16'($urandom_range(1, 40)), 16'($urandom_range(1, 40)),
				16'($urandom_range(1, 40))}
		};
		clear_bank();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (rows[i])
			offer_word(rows[i].fn, rows[i].sel, rows[i].lvl, rows[i].per,
				rows[i].known, rows[i].want);
		random_words(80);
		settle_bank();
		for (int ph = 0; ph < 6; ph++) begin
			tx_quiet = (ph == 1 || ph == 4);
			rx_quiet = (ph == 2 || ph == 4);
			program_timing(setups[ph][0], setups[ph][1], setups[ph][2]);
			random_words(45);
			// hold results back while words keep coming
			if (ph == 0 || ph == 4)
				hold_req = 1'b1;
			// drain everything before carrying on
			if (ph == 3)
				settle_bank();
			random_words(45);
			settle_bank();
		end
		if (mismatches == 0 && expected_levels.size() == 0)
			$display("multi_led_pattern_controller: match");
		else
			$display("multi_led_pattern_controller: mismatch");
		$finish;
	end

endmodule
